FILE: src/square_matrix_multiply_core_assert.svh
// assertion macros for the square matrix multiply core
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_ASSERT_SVH

// same-cycle implication
`define SMM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("square matrix multiply core: assertion failed");

// next-cycle implication
`define SMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("square matrix multiply core: assertion failed");

`endif

FILE: src/smm_pkg.sv
// shared types and constants of the square matrix multiply core
package smm_pkg;

  localparam int MAX_SIZE_DEF     = 8;
  localparam int ELEMENT_BITS_DEF = 16;
  localparam int IDX_BITS         = 3;
  localparam int VALUE_BITS       = 16;
  localparam int OUT_BITS         = 35;
  localparam int SIZE_BITS        = 4;
  localparam int KIND_BITS        = 2;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 4'd8;

  localparam logic [KIND_BITS-1:0] KIND_WRITE_A = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_WRITE_B = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_COMPUTE = 2'd2;

  // control travelling with an a element along the chain
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } link_t;

  // element write into the b columns held by the cells
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } b_wr_t;

endpackage

FILE: src/smm_cell.sv
// one chain cell: holds one column of b and accumulates one element of c
module smm_cell #(
  parameter int MAX_SIZE     = smm_pkg::MAX_SIZE_DEF,
  parameter int ELEMENT_BITS = smm_pkg::ELEMENT_BITS_DEF,
  parameter int COLUMN       = 0
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  smm_pkg::b_wr_t                          b_wr,
  input  logic [ELEMENT_BITS-1:0]                 b_data,
  input  smm_pkg::link_t                          link_in,
  input  logic signed [ELEMENT_BITS-1:0]          a_in,
  input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] k_in,
  output smm_pkg::link_t                          link_out,
  output logic signed [ELEMENT_BITS-1:0]          a_out,
  output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] k_out,
  output logic signed [smm_pkg::OUT_BITS-1:0]     acc,
  output logic                                    done
);

  localparam int KW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int PW = 2 * ELEMENT_BITS;
  localparam int OW = smm_pkg::OUT_BITS;
  localparam int IW = smm_pkg::IDX_BITS;

  logic signed [ELEMENT_BITS-1:0] b_col [MAX_SIZE];
  logic signed [ELEMENT_BITS-1:0] b_rd;
  logic signed [PW-1:0]           prod;
  logic                           prod_valid;
  logic                           prod_first;
  logic                           prod_last;
  logic [PW+OW-1:0]               prod_ext;
  logic signed [OW-1:0]           prod_w;

  always_ff @(posedge clk) begin
    if (b_wr.en && b_wr.col == IW'(COLUMN) && int'(b_wr.row) < MAX_SIZE) begin
      b_col[KW'(b_wr.row)] <= b_data;
    end
  end

  assign b_rd     = b_col[k_in];
  assign prod_ext = {{OW{prod[PW-1]}}, prod};
  assign prod_w   = prod_ext[OW-1:0];

  // multiply stage and hand-on to the neighbour
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out   <= '0;
      prod_valid <= 1'b0;
    end else begin
      link_out   <= link_in;
      prod_valid <= link_in.valid;
    end
    a_out      <= a_in;
    k_out      <= k_in;
    prod       <= a_in * b_rd;
    prod_first <= link_in.first;
    prod_last  <= link_in.last;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_valid && prod_last;
    end
    if (prod_valid) begin
      acc <= prod_first ? prod_w : acc + prod_w;
    end
  end

endmodule

FILE: src/square_matrix_multiply_core.sv
// square matrix multiply core: top level with a store, sequencer and cell chain
// A compute transaction streams each row of A, one element per cycle, down a
// chain of one cell per column; every cell holds its column of B and
// accumulates one element of C. Per row it feeds the row, waits for the row
// to reach the last active cell, and hands the results out one per cycle
// while the output is not stalled.
// No input is taken while a compute transaction is in progress.
`include "square_matrix_multiply_core_assert.svh"

module square_matrix_multiply_core #(
  parameter int MAX_SIZE     = smm_pkg::MAX_SIZE_DEF,
  parameter int ELEMENT_BITS = smm_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [smm_pkg::SIZE_BITS-1:0]           cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [smm_pkg::KIND_BITS-1:0]           kind,
  input  logic [smm_pkg::IDX_BITS-1:0]            row_index,
  input  logic [smm_pkg::IDX_BITS-1:0]            col_index,
  input  logic signed [smm_pkg::VALUE_BITS-1:0]   element_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [smm_pkg::IDX_BITS-1:0]            out_row,
  output logic [smm_pkg::IDX_BITS-1:0]            out_col,
  output logic signed [smm_pkg::OUT_BITS-1:0]     product_value,
  output logic                                    last
);

  localparam int KW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
  localparam int IW = smm_pkg::IDX_BITS;
  localparam int SW = smm_pkg::SIZE_BITS;
  localparam int OW = smm_pkg::OUT_BITS;
  localparam int VW = smm_pkg::VALUE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FEED  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t                  state;
  logic [SW-1:0]           size;
  logic [SW-1:0]           size_clamp;
  logic [KW-1:0]           n_last;
  logic [KW-1:0]           row;
  logic [KW-1:0]           col;
  logic [KW-1:0]           k;
  logic                    accept;
  logic                    in_range;
  logic                    out_free;
  logic [ELEMENT_BITS-1:0] elem;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr;

  logic [ELEMENT_BITS-1:0] a_mem [MAX_SIZE * MAX_SIZE];

  smm_pkg::link_t                 link  [MAX_SIZE];
  logic signed [ELEMENT_BITS-1:0] a_chn [MAX_SIZE];
  logic [KW-1:0]                  k_chn [MAX_SIZE];
  logic signed [OW-1:0]           acc   [MAX_SIZE];
  logic [MAX_SIZE-1:0]            done;
  smm_pkg::b_wr_t                 b_wr;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (int'(row_index) < MAX_SIZE) && (int'(col_index) < MAX_SIZE);
  assign out_free = !out_valid || !out_stall;
  assign waddr    = AW'(row_index) * AW'(MAX_SIZE) + AW'(col_index);
  assign raddr    = AW'(row) * AW'(MAX_SIZE) + AW'(k);

  generate
    if (ELEMENT_BITS > VW) begin : g_wide
      assign elem = {{(ELEMENT_BITS - VW){1'b0}}, element_value};
    end else begin : g_narrow
      assign elem = element_value[ELEMENT_BITS-1:0];
    end
  endgenerate

  always_comb begin
    if (size == '0) begin
      size_clamp = SW'(1);
    end else if (int'(size) > MAX_SIZE) begin
      size_clamp = SW'(MAX_SIZE);
    end else begin
      size_clamp = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= smm_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      size <= cfg_data;
    end
  end

  // a store
  always_ff @(posedge clk) begin
    if (accept && kind == smm_pkg::KIND_WRITE_A && in_range) begin
      a_mem[waddr] <= elem;
    end
    a_chn[0] <= a_mem[raddr];
  end

  always_comb begin
    b_wr.en  = accept && kind == smm_pkg::KIND_WRITE_B;
    b_wr.row = row_index;
    b_wr.col = col_index;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      link[0]   <= '0;
      row       <= '0;
      col       <= '0;
      k         <= '0;
    end else begin
      link[0].valid <= (state == ST_FEED);
      link[0].first <= (k == '0);
      link[0].last  <= (k == n_last);
      if (out_valid && !out_stall && state != ST_DRAIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && kind == smm_pkg::KIND_COMPUTE) begin
            n_last <= KW'(size_clamp - SW'(1));
            row    <= '0;
            k      <= '0;
            state  <= ST_FEED;
          end
        end
        ST_FEED: begin
          k_chn[0] <= k;
          if (k == n_last) begin
            k     <= '0;
            state <= ST_WAIT;
          end else begin
            k <= k + KW'(1);
          end
        end
        ST_WAIT: begin
          if (done[n_last]) begin
            col   <= '0;
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_row       <= IW'(row);
            out_col       <= IW'(col);
            product_value <= acc[col];
            last          <= (row == n_last) && (col == n_last);
            col           <= col + KW'(1);
            if (col == n_last) begin
              if (row == n_last) begin
                state <= ST_IDLE;
              end else begin
                row   <= row + KW'(1);
                state <= ST_FEED;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // cell chain
  genvar c;
  generate
    for (c = 0; c < MAX_SIZE; c++) begin : g_cell
      if (c < MAX_SIZE - 1) begin : g_mid
        smm_cell #(
          .MAX_SIZE     (MAX_SIZE),
          .ELEMENT_BITS (ELEMENT_BITS),
          .COLUMN       (c)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .b_wr     (b_wr),
          .b_data   (elem),
          .link_in  (link[c]),
          .a_in     (a_chn[c]),
          .k_in     (k_chn[c]),
          .link_out (link[c+1]),
          .a_out    (a_chn[c+1]),
          .k_out    (k_chn[c+1]),
          .acc      (acc[c]),
          .done     (done[c])
        );
      end else begin : g_tail
        smm_cell #(
          .MAX_SIZE     (MAX_SIZE),
          .ELEMENT_BITS (ELEMENT_BITS),
          .COLUMN       (c)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .b_wr     (b_wr),
          .b_data   (elem),
          .link_in  (link[c]),
          .a_in     (a_chn[c]),
          .k_in     (k_chn[c]),
          .link_out (),
          .a_out    (),
          .k_out    (),
          .acc      (acc[c]),
          .done     (done[c])
        );
      end
    end
  endgenerate

  `SMM_ASSERT_NEXT(a_compute_starts, clk, rst, accept && kind == smm_pkg::KIND_COMPUTE, state == ST_FEED)
  `SMM_ASSERT_NOW(a_done_in_wait, clk, rst, state != ST_IDLE && done[n_last], state == ST_WAIT)
  `SMM_ASSERT_NOW(a_last_on_diagonal, clk, rst, out_valid && last, out_row == out_col)

endmodule

FILE: dv/smm_checker.sv
// product checker for the square matrix multiply core: watches both channels, predicts and compares
module smm_checker
  import smm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [SIZE_BITS-1:0]        cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [KIND_BITS-1:0]        kind,
  input  logic [IDX_BITS-1:0]         row_index,
  input  logic [IDX_BITS-1:0]         col_index,
  input  logic signed [VALUE_BITS-1:0] element_value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [IDX_BITS-1:0]         out_row,
  input  logic [IDX_BITS-1:0]         out_col,
  input  logic signed [OUT_BITS-1:0]  product_value,
  input  logic                        last,
  output int                          fail_count,
  output int                          pending,
  output int                          items_seen,
  output int                          computes_seen,
  output int                          elements_seen
);

  localparam int N = MAX_SIZE_DEF;

  typedef struct {
    logic [IDX_BITS-1:0]        row;
    logic [IDX_BITS-1:0]        col;
    logic signed [OUT_BITS-1:0] value;
    logic                       last;
  } product_elem_t;

  logic signed [VALUE_BITS-1:0] a_elems [N*N];
  logic signed [VALUE_BITS-1:0] b_elems [N*N];
  logic [SIZE_BITS-1:0]         dim_setting;
  product_elem_t                product_q [$];

  function automatic int active_dim(logic [SIZE_BITS-1:0] s);
    if (s == '0) return 1;
    if (s > N) return N;
    return int'(s);
  endfunction

  // every element of the product, row by row
  task automatic queue_product();
    int n;
    longint acc;
    product_elem_t p;
    n = active_dim(dim_setting);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(a_elems[r*N + k]) * longint'(b_elems[k*N + c]);
        end
        p.row   = IDX_BITS'(r);
        p.col   = IDX_BITS'(c);
        p.value = OUT_BITS'(acc);
        p.last  = (r == n - 1) && (c == n - 1);
        product_q.push_back(p);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    product_elem_t want;
    if (rst) begin
      dim_setting = SIZE_RESET;
      for (int i = 0; i < N*N; i++) begin
        a_elems[i] = '0;
        b_elems[i] = '0;
      end
      product_q.delete();
      fail_count    = 0;
      items_seen    = 0;
      computes_seen = 0;
      elements_seen = 0;
    end else begin
      if (cfg_write) begin
        dim_setting = cfg_data;
      end
      if (out_valid && !out_stall) begin
        elements_seen++;
        if (product_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected product element: row %0d col %0d value %0d last %0b",
                     out_row, out_col, product_value, last);
          end
        end else begin
          want = product_q.pop_front();
          if (out_row !== want.row || out_col !== want.col ||
              product_value !== want.value || last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("element %0d differs: expected row %0d col %0d value %0d last %0b",
                       elements_seen, want.row, want.col, want.value, want.last);
              $display("  got row %0d col %0d value %0d last %0b",
                       out_row, out_col, product_value, last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        items_seen++;
        case (kind)
          KIND_WRITE_A: begin
            a_elems[int'(row_index)*N + int'(col_index)] = element_value;
          end
          KIND_WRITE_B: begin
            b_elems[int'(row_index)*N + int'(col_index)] = element_value;
          end
          KIND_COMPUTE: begin
            computes_seen++;
            queue_product();
          end
          default: ;
        endcase
      end
    end
    pending = product_q.size();
  end

endmodule

FILE: dv/tb_top.sv
// top of the square matrix multiply core testbench: clock, reset, stimulus and verdict
module tb_top;
  import smm_pkg::*;

  localparam int N            = MAX_SIZE_DEF;
  localparam int ITEM_TARGET  = 420;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [KIND_BITS-1:0]        KIND_NOP = 2'd3;
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 16'sh7fff;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [SIZE_BITS-1:0]         cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [KIND_BITS-1:0]         kind = '0;
  logic [IDX_BITS-1:0]          row_index = '0;
  logic [IDX_BITS-1:0]          col_index = '0;
  logic signed [VALUE_BITS-1:0] element_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [IDX_BITS-1:0]          out_row;
  logic [IDX_BITS-1:0]          out_col;
  logic signed [OUT_BITS-1:0]   product_value;
  logic                         last;

  int fail_count, pending, items_seen, computes_seen, elements_seen;
  int sent_count = 0;
  int cycle_count = 0;
  bit pressure_done = 1'b0;
  bit a_done [N*N];
  bit b_done [N*N];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  square_matrix_multiply_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .row_index(row_index),
    .col_index(col_index), .element_value(element_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_row(out_row), .out_col(out_col),
    .product_value(product_value), .last(last)
  );

  smm_checker product_check (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .row_index(row_index),
    .col_index(col_index), .element_value(element_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_row(out_row), .out_col(out_col),
    .product_value(product_value), .last(last),
    .fail_count(fail_count), .pending(pending), .items_seen(items_seen),
    .computes_seen(computes_seen), .elements_seen(elements_seen)
  );

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped by the cycle limit after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stretch with no idling on either side
  function automatic bit quiet_window();
    return sent_count >= 250 && sent_count < 330;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int t;
    t = $urandom_range(511);
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return VALUE_BITS'(t - 256);
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input logic [KIND_BITS-1:0] k, input int r, input int c,
                           input logic signed [VALUE_BITS-1:0] v);
    while (!quiet_window() && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    row_index     <= IDX_BITS'(r);
    col_index     <= IDX_BITS'(c);
    element_value <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (k == KIND_WRITE_A) a_done[r*N + c] = 1'b1;
    if (k == KIND_WRITE_B) b_done[r*N + c] = 1'b1;
    if (k != KIND_NOP) sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(input logic [SIZE_BITS-1:0] setting);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= setting;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // write anything still unwritten that the next product reads
  task automatic fill_missing(input int n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!a_done[r*N + c]) send_item(KIND_WRITE_A, r, c, pick_value());
        if (!b_done[r*N + c]) send_item(KIND_WRITE_B, r, c, pick_value());
      end
    end
  endtask

  task automatic run_phase(input logic [SIZE_BITS-1:0] setting);
    int n, computes, writes, r, c;
    logic [KIND_BITS-1:0] k;
    set_size(setting);
    n = (setting == 0) ? 1 : (setting > N) ? N : int'(setting);
    computes = $urandom_range(3, 1);
    repeat (computes) begin
      writes = $urandom_range(2*n + 2);
      repeat (writes) begin
        if ($urandom_range(11) == 0) begin
          send_item(KIND_NOP, $urandom_range(7), $urandom_range(7), VALUE_BITS'($urandom));
        end else begin
          k = $urandom_range(1) ? KIND_WRITE_B : KIND_WRITE_A;
          if ($urandom_range(3) == 0) begin
            r = $urandom_range(7);
            c = $urandom_range(7);
          end else begin
            r = $urandom_range(n - 1);
            c = $urandom_range(n - 1);
          end
          send_item(k, r, c, pick_value());
        end
      end
      fill_missing(n);
      send_item(KIND_COMPUTE, $urandom_range(7), $urandom_range(7), VALUE_BITS'($urandom));
    end
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    int hold_left;
    hold_left = 0;
    @(negedge clk);
    forever begin
      if (!pressure_done && sent_count >= 140) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet_window() && ($urandom_range(99) < 36);
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [SIZE_BITS-1:0] sweep [9];
    sweep = '{4'd2, 4'd8, 4'd3, 4'd0, 4'd5, 4'd1, 4'd7, 4'd4, 4'd6};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single element: sign extremes, writes outside the used size, unused kind
    set_size(4'd1);
    send_item(KIND_WRITE_A, 0, 0, VAL_MIN);
    send_item(KIND_WRITE_B, 0, 0, VAL_MIN);
    send_item(KIND_COMPUTE, 0, 0, '0);
    send_item(KIND_WRITE_B, 0, 0, VAL_MAX);
    send_item(KIND_COMPUTE, 7, 7, VAL_MIN);
    send_item(KIND_WRITE_A, 0, 0, VAL_MAX);
    send_item(KIND_COMPUTE, 7, 0, VAL_MAX);
    send_item(KIND_WRITE_A, 7, 7, 16'sh5a5a);
    send_item(KIND_WRITE_B, 7, 7, -16'sd1);
    send_item(KIND_NOP, 7, 7, -16'sd1);
    send_item(KIND_NOP, 0, 0, '0);
    send_item(KIND_WRITE_A, 0, 0, '0);
    send_item(KIND_COMPUTE, 0, 7, -16'sd1);
    set_size(4'd0);
    send_item(KIND_WRITE_A, 0, 0, -16'sd1);
    send_item(KIND_WRITE_B, 0, 0, -16'sd1);
    send_item(KIND_COMPUTE, 3, 5, 16'sh00ff);

    // full size through an oversized setting, every element at the negative extreme
    set_size(4'd15);
    for (int i = 0; i < N*N; i++) begin
      send_item(KIND_WRITE_A, i / N, i % N, VAL_MIN);
      send_item(KIND_WRITE_B, i / N, i % N, VAL_MIN);
    end
    send_item(KIND_COMPUTE, 0, 0, '0);

    foreach (sweep[i]) run_phase(sweep[i]);
    while (sent_count < ITEM_TARGET) run_phase(SIZE_BITS'($urandom_range(15)));

    wait_idle();
    $display("covered %0d input transactions, %0d of them computes, at sizes 0 to 15",
             items_seen, computes_seen);
    $display("checked %0d product elements, with one output hold-off of %0d cycles",
             elements_seen, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
